// ----- rtl/core/dcl_pkg.sv -----
package dcl_pkg;

	typedef enum logic [2:0] {
		PH_INIT        = 3'd0,
		PH_REQUESTING  = 3'd1,
		PH_BOUND       = 3'd2,
		PH_RENEWING    = 3'd3,
		PH_REBINDING   = 3'd4,
		PH_RENEW_ASKED = 3'd5,
		PH_RELEASED    = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		LS_NONE   = 2'd0,
		LS_KERNEL = 2'd1,
		LS_RAW    = 2'd2
	} listen_t;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_PACKET  = 2'd1;
	localparam logic [1:0] FUNC_RENEW   = 2'd2;
	localparam logic [1:0] FUNC_RELEASE = 2'd3;

	localparam logic [2:0] KIND_OFFER = 3'd1;
	localparam logic [2:0] KIND_ACK   = 3'd2;
	localparam logic [2:0] KIND_NAK   = 3'd3;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_DISCOVER = 3'd1;
	localparam logic [2:0] ACT_SELECT   = 3'd2;
	localparam logic [2:0] ACT_RENEW    = 3'd3;
	localparam logic [2:0] ACT_REBIND   = 3'd4;
	localparam logic [2:0] ACT_RELEASE  = 3'd5;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_BOUND   = 2'd1;
	localparam logic [1:0] EV_RENEWED = 2'd2;
	localparam logic [1:0] EV_NAK     = 2'd3;

	localparam logic [1:0] CFG_INITIAL_IP    = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_LEASE = 2'd1;
	localparam logic [1:0] CFG_IDLE_BACKOFF  = 2'd2;

	localparam logic [31:0] LEASE_SLICE       = 32'd14400;
	localparam logic [31:0] PARKED_DEADLINE   = 32'h7fff_ffff;
	localparam logic [31:0] DEFAULT_LEASE_RST = 32'd3600;
	localparam logic [15:0] IDLE_BACKOFF_RST  = 16'd60;

	localparam logic [1:0]  MAX_TRIES     = 2'd3;
	localparam logic [1:0]  LAST_TRY      = 2'd2;
	localparam logic [31:0] WAIT_SHORT    = 32'd2;
	localparam logic [31:0] WAIT_DISC_END = 32'd4;
	localparam logic [31:0] WAIT_REQ_END  = 32'd10;

	typedef struct packed {
		phase_t      phase;
		listen_t     listen;
		logic [1:0]  tries;
		logic [31:0] cur_xid;
		logic [31:0] server_ip;
		logic [31:0] req_ip;
		logic [31:0] lease_len;
		logic [31:0] renew_mark;
		logic [31:0] rebind_mark;
		logic [31:0] lease_start;
		logic [31:0] deadline;
	} state_t;

	localparam state_t STATE_RST = '{
		phase: PH_INIT, listen: LS_RAW, tries: 2'd0, cur_xid: 32'd0, server_ip: 32'd0,
		req_ip: 32'd0, lease_len: 32'd0, renew_mark: 32'd0, rebind_mark: 32'd0,
		lease_start: 32'd0, deadline: 32'd0
	};

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_secs;
		logic [31:0] fresh_xid;
		logic [31:0] pkt_xid;
		logic [2:0]  msg_kind;
		logic        has_server_id;
		logic [31:0] server_id;
		logic [31:0] your_ip;
		logic        has_lease;
		logic [31:0] lease_in;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] out_xid;
		logic [31:0] out_server;
		logic [31:0] out_ip;
		logic [1:0]  script_event;
		logic        deconfig;
		listen_t     listen_kind;
		phase_t      client_state;
		logic [31:0] lease_out;
		logic        no_lease;
		logic [31:0] deadline_out;
	} result_t;

endpackage

// ----- rtl/core/dhcp_client_lease_fsm_top.sv -----
// An accepted item waits in the item register until the output can advance; its
// result is then registered in the result register. Throughput: one item per
// cycle unless result_stall holds; the state update of an item is combinational.
// Reset (arst_n low, asynchronous) returns the lease state to init with the raw
// listener, clears the pipeline and loads the default configuration values.
module dhcp_client_lease_fsm_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [31:0] now_secs,
	input  logic [31:0] fresh_xid,
	input  logic [31:0] pkt_xid,
	input  logic [2:0]  msg_kind,
	input  logic        has_server_id,
	input  logic [31:0] server_id,
	input  logic [31:0] your_ip,
	input  logic        has_lease,
	input  logic [31:0] lease_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  action,
	output logic [31:0] out_xid,
	output logic [31:0] out_server,
	output logic [31:0] out_ip,
	output logic [1:0]  script_event,
	output logic        deconfig,
	output logic [1:0]  listen_kind,
	output logic [2:0]  client_state,
	output logic [31:0] lease_out,
	output logic        no_lease,
	output logic [31:0] deadline_out
);
	import dcl_pkg::*;

	state_t      st_q;
	state_t      st_nx;
	item_t       item_s1;
	logic        valid_s1;
	result_t     res_nx;
	result_t     res_s2;
	logic        valid_s2;
	logic [31:0] default_lease_q;
	logic [15:0] idle_backoff_q;
	logic        adv;
	logic        fire;
	logic        take;
	logic        cfg_we;

	assign adv        = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && adv;
	assign item_stall = valid_s1 && !adv;
	assign take       = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;

	dcl_step u_step (
		.st            (st_q),
		.it            (item_s1),
		.default_lease (default_lease_q),
		.idle_backoff  (idle_backoff_q),
		.nx            (st_nx),
		.res           (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_lease_q <= DEFAULT_LEASE_RST;
			idle_backoff_q  <= IDLE_BACKOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEFAULT_LEASE: default_lease_q <= cfg_data;
				CFG_IDLE_BACKOFF:  idle_backoff_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
		end else if (fire) begin
			st_q <= st_nx;
		end else if (cfg_we && (cfg_index == CFG_INITIAL_IP)) begin
			st_q.req_ip <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{func: func, now_secs: now_secs, fresh_xid: fresh_xid,
				pkt_xid: pkt_xid, msg_kind: msg_kind, has_server_id: has_server_id,
				server_id: server_id, your_ip: your_ip, has_lease: has_lease,
				lease_in: lease_in};
		end
		if (fire) begin
			res_s2 <= res_nx;
		end
	end

	assign result_valid = valid_s2;
	assign action       = res_s2.action;
	assign out_xid      = res_s2.out_xid;
	assign out_server   = res_s2.out_server;
	assign out_ip       = res_s2.out_ip;
	assign script_event = res_s2.script_event;
	assign deconfig     = res_s2.deconfig;
	assign listen_kind  = res_s2.listen_kind;
	assign client_state = res_s2.client_state;
	assign lease_out    = res_s2.lease_out;
	assign no_lease     = res_s2.no_lease;
	assign deadline_out = res_s2.deadline_out;

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.action == ACT_NONE)) |->
		((res_s2.out_xid == '0) && (res_s2.out_server == '0) && (res_s2.out_ip == '0)))
		else $error("Result without a packet to send carries packet fields.");

	a_bound_not_listening: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_BOUND) |-> (st_q.listen == LS_NONE))
		else $error("Bound client still has a listener open.");

	a_backoff_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.no_lease) |->
		((res_s2.action == ACT_NONE) && (res_s2.client_state == PH_INIT)))
		else $error("Backoff flagged outside the init phase or with a packet.");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("Processed item produced no result.");

endmodule

// ----- rtl/core/dcl_step.sv -----
module dcl_step (
	input  dcl_pkg::state_t  st,
	input  dcl_pkg::item_t   it,
	input  logic [31:0]      default_lease,
	input  logic [15:0]      idle_backoff,
	output dcl_pkg::state_t  nx,
	output dcl_pkg::result_t res
);
	import dcl_pkg::*;

	// True when the remaining interval d is at most lease / 14400 + 1.
	function automatic logic interval_spent(input logic [31:0] d, input logic [31:0] lease);
		logic [31:0] dm1;
		logic [45:0] prod;
		begin
			dm1  = d - 32'd1;
			prod = {14'd0, dm1} * {14'd0, LEASE_SLICE};
			interval_spent = (d == 32'd0) || (prod <= {14'd0, lease});
		end
	endfunction

	logic [31:0] d_renew;
	logic [31:0] d_rebind;
	logic [31:0] ack_lease;
	logic [34:0] lease_x7;
	logic        pkt_ok;

	assign d_renew   = st.rebind_mark - st.renew_mark;
	assign d_rebind  = st.lease_len - st.rebind_mark;
	assign ack_lease = it.has_lease ? it.lease_in : default_lease;
	assign lease_x7  = {ack_lease, 3'b000} - {3'b000, ack_lease};
	assign pkt_ok    = (st.listen != LS_NONE) && (it.pkt_xid == st.cur_xid) &&
		((it.msg_kind == KIND_OFFER) || (it.msg_kind == KIND_ACK) ||
		 (it.msg_kind == KIND_NAK));

	always_comb begin
		nx                = st;
		res               = '0;

		unique case (it.func)
			FUNC_TICK: begin
				if (it.now_secs >= st.deadline) begin
					unique case (st.phase)
						PH_INIT: begin
							if (st.tries < MAX_TRIES) begin
								if (st.tries == 2'd0) begin
									nx.cur_xid = it.fresh_xid;
								end
								res.action  = ACT_DISCOVER;
								res.out_xid = nx.cur_xid;
								res.out_ip  = st.req_ip;
								nx.deadline = it.now_secs +
									((st.tries == LAST_TRY) ? WAIT_DISC_END : WAIT_SHORT);
								nx.tries    = st.tries + 2'd1;
							end else begin
								nx.tries     = 2'd0;
								nx.deadline  = it.now_secs + {16'd0, idle_backoff};
								res.no_lease = 1'b1;
							end
						end
						PH_REQUESTING, PH_RENEW_ASKED: begin
							if (st.tries < MAX_TRIES) begin
								res.action     = (st.phase == PH_RENEW_ASKED) ?
									ACT_RENEW : ACT_SELECT;
								res.out_xid    = st.cur_xid;
								res.out_server = st.server_ip;
								res.out_ip     = st.req_ip;
								nx.deadline    = it.now_secs +
									((st.tries == LAST_TRY) ? WAIT_REQ_END : WAIT_SHORT);
								nx.tries       = st.tries + 2'd1;
							end else begin
								res.deconfig = (st.phase == PH_RENEW_ASKED);
								nx.phase     = PH_INIT;
								nx.deadline  = it.now_secs;
								nx.tries     = 2'd0;
								nx.listen    = LS_RAW;
							end
						end
						PH_BOUND, PH_RENEWING: begin
							nx.phase = PH_RENEWING;
							if (st.phase == PH_BOUND) begin
								nx.listen = LS_KERNEL;
							end
							if (interval_spent(d_renew, st.lease_len)) begin
								nx.phase    = PH_REBINDING;
								nx.deadline = it.now_secs + d_renew;
							end else begin
								res.action     = ACT_RENEW;
								res.out_xid    = st.cur_xid;
								res.out_server = st.server_ip;
								res.out_ip     = st.req_ip;
								nx.renew_mark  = st.renew_mark + {1'b0, d_renew[31:1]};
								nx.deadline    = nx.renew_mark + st.lease_start;
							end
						end
						PH_REBINDING: begin
							if (interval_spent(d_rebind, st.lease_len)) begin
								res.deconfig = 1'b1;
								nx.phase     = PH_INIT;
								nx.deadline  = it.now_secs;
								nx.tries     = 2'd0;
								nx.listen    = LS_RAW;
							end else begin
								res.action     = ACT_REBIND;
								res.out_xid    = st.cur_xid;
								res.out_ip     = st.req_ip;
								nx.rebind_mark = st.rebind_mark + {1'b0, d_rebind[31:1]};
								nx.deadline    = nx.rebind_mark + st.lease_start;
							end
						end
						PH_RELEASED: begin
							nx.deadline = PARKED_DEADLINE;
						end
						default: begin
						end
					endcase
				end
			end
			FUNC_PACKET: begin
				if (pkt_ok) begin
					if (st.phase == PH_INIT) begin
						if ((it.msg_kind == KIND_OFFER) && it.has_server_id) begin
							nx.server_ip   = it.server_id;
							nx.cur_xid     = it.pkt_xid;
							nx.req_ip      = it.your_ip;
							nx.phase       = PH_REQUESTING;
							nx.deadline    = it.now_secs;
							nx.tries       = 2'd0;
						end
					end else if ((st.phase == PH_REQUESTING) || (st.phase == PH_RENEW_ASKED) ||
						(st.phase == PH_RENEWING) || (st.phase == PH_REBINDING)) begin
						if (it.msg_kind == KIND_ACK) begin
							nx.lease_len   = ack_lease;
							nx.renew_mark  = {1'b0, ack_lease[31:1]};
							nx.rebind_mark = lease_x7[34:3];
							nx.lease_start = it.now_secs;
							nx.deadline    = {1'b0, ack_lease[31:1]} + it.now_secs;
							nx.req_ip      = it.your_ip;
							res.script_event = ((st.phase == PH_RENEWING) ||
								(st.phase == PH_REBINDING)) ? EV_RENEWED : EV_BOUND;
							nx.phase       = PH_BOUND;
							nx.listen      = LS_NONE;
						end else if (it.msg_kind == KIND_NAK) begin
							res.script_event = EV_NAK;
							res.deconfig     = (st.phase != PH_REQUESTING);
							nx.req_ip        = '0;
							nx.phase         = PH_INIT;
							nx.deadline      = it.now_secs;
							nx.tries         = 2'd0;
							nx.listen        = LS_RAW;
						end
					end
				end
			end
			FUNC_RENEW: begin
				unique case (st.phase)
					PH_BOUND: begin
						nx.listen = LS_KERNEL;
						nx.phase  = PH_RENEW_ASKED;
					end
					PH_RENEWING, PH_REBINDING: begin
						nx.phase = PH_RENEW_ASKED;
					end
					PH_RENEW_ASKED: begin
						res.deconfig = 1'b1;
						nx.listen    = LS_RAW;
						nx.phase     = PH_INIT;
					end
					PH_REQUESTING, PH_RELEASED: begin
						nx.listen = LS_RAW;
						nx.phase  = PH_INIT;
					end
					default: begin
					end
				endcase
				nx.tries    = 2'd0;
				nx.deadline = '0;
			end
			default: begin
				if ((st.phase == PH_BOUND) || (st.phase == PH_RENEWING) ||
					(st.phase == PH_REBINDING)) begin
					res.action     = ACT_RELEASE;
					res.out_server = st.server_ip;
					res.out_ip     = st.req_ip;
					res.deconfig   = 1'b1;
				end
				nx.listen   = LS_NONE;
				nx.phase    = PH_RELEASED;
				nx.deadline = PARKED_DEADLINE;
			end
		endcase

		res.listen_kind  = nx.listen;
		res.client_state = nx.phase;
		res.lease_out    = nx.lease_len;
		res.deadline_out = nx.deadline;
	end

endmodule
